>>> rtl/kma_pkg.sv
// kma_pkg: shared constants and ASCII lookup tables for the key matrix decoder.
// No dependencies; imported by kma_scan and key_matrix_to_ascii.
`default_nettype none

package kma_pkg;

    localparam int unsigned MatrixW  = 56;
    localparam int unsigned NumCols  = 8;
    localparam int unsigned NumRows  = 7;
    localparam int unsigned TableLen = 49;
    localparam int unsigned ShiftBit = 55;
    localparam int unsigned CharW    = 7;

    typedef logic [MatrixW-1:0] t_matrix;
    typedef logic [CharW-1:0]   t_char;
    typedef logic [5:0]         t_index;

    localparam t_char NoCode = '0;

    localparam t_char PlainTab [TableLen] = '{
        7'h40, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47,
        7'h48, 7'h49, 7'h4A, 7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F,
        7'h50, 7'h51, 7'h52, 7'h53, 7'h54, 7'h55, 7'h56, 7'h57,
        7'h58, 7'h59, 7'h5A, 7'h00, 7'h00, 7'h08, 7'h00, 7'h20,
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h3A, 7'h3B, 7'h2C, 7'h2D, 7'h2E, 7'h2F,
        7'h0A
    };

    localparam t_char ShiftTab [TableLen] = '{
        7'h40, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47,
        7'h48, 7'h49, 7'h4A, 7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F,
        7'h50, 7'h51, 7'h52, 7'h53, 7'h54, 7'h55, 7'h56, 7'h57,
        7'h58, 7'h59, 7'h5A, 7'h00, 7'h00, 7'h08, 7'h00, 7'h20,
        7'h00, 7'h21, 7'h22, 7'h23, 7'h24, 7'h25, 7'h26, 7'h27,
        7'h28, 7'h29, 7'h2A, 7'h2B, 7'h3C, 7'h3D, 7'h3E, 7'h3F,
        7'h0A
    };

endpackage

`default_nettype wire

>>> rtl/kma_scan.sv
// kma_scan: priority encoder over the key matrix and ASCII table lookup.
// Depends on kma_pkg.
`default_nettype none

module kma_scan (
    input  wire kma_pkg::t_matrix i_key_matrix,
    output kma_pkg::t_char        o_code
);
    import kma_pkg::*;

    logic [NumCols-1:0] col_any;
    logic [2:0]         col_sel;
    logic [NumRows-1:0] col_bits;
    logic [2:0]         row_sel;
    logic               hit;
    t_index             idx;
    logic               shift;

    always_comb begin
        col_any = '0;
        for (int c = 0; c < NumCols; c++) begin
            for (int r = 0; r < NumRows; r++) begin
                col_any[c] = col_any[c] | i_key_matrix[r*NumCols + c];
            end
        end
    end

    // lowest pressed column
    always_comb begin
        col_sel = '0;
        for (int c = NumCols-1; c >= 0; c--) begin
            if (col_any[c]) begin
                col_sel = 3'(c);
            end
        end
    end

    always_comb begin
        for (int r = 0; r < NumRows; r++) begin
            col_bits[r] = i_key_matrix[r*NumCols + 32'(col_sel)];
        end
    end

    // lowest pressed row in that column
    always_comb begin
        row_sel = '0;
        for (int r = NumRows-1; r >= 0; r--) begin
            if (col_bits[r]) begin
                row_sel = 3'(r);
            end
        end
    end

    assign hit   = |col_any;
    assign idx   = {row_sel, col_sel};
    assign shift = i_key_matrix[ShiftBit];

    always_comb begin
        if (!hit || (idx >= 6'(TableLen))) begin
            o_code = NoCode;
        end else if (shift) begin
            o_code = ShiftTab[idx];
        end else begin
            o_code = PlainTab[idx];
        end
    end

endmodule

`default_nettype wire

>>> rtl/key_matrix_to_ascii.sv
// key_matrix_to_ascii: top level; input register, scan/lookup, change filter,
// output register. Depends on kma_pkg and kma_scan.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one word per tick: a 56-bit
//   snapshot of the 8x7 key matrix, bit row*8+column set for a pressed key.
//   Output channel (o_valid / i_stall) carries one word per newly pressed key:
//   the 7-bit ASCII code, never zero. A tick whose code matches the previous
//   tick's code, or whose code is zero, produces no output word.
//   The input register captures the word at the accept edge; the result
//   register then takes the code and raises o_valid once the output is free.
//   Throughput: one tick per cycle while o_stall is low; the scan, lookup and
//   compare against the stored code are one combinational pass.
//   The input register keeps taking words while a result waits at the
//   output; when the receiver stalls and a second result is ready, the input
//   register holds and o_stall rises until the output word is taken.
//   Reset (synchronous, active low) empties both registers and clears the
//   stored last code to zero.
`default_nettype none

module key_matrix_to_ascii (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_stall,
    input  wire kma_pkg::t_matrix i_key_matrix,
    output logic                  o_valid,
    input  wire                   i_stall,
    output kma_pkg::t_char        o_character
);
    import kma_pkg::*;

    logic    r_s1_vld, n_s1_vld;
    t_matrix r_km;
    t_char   r_last, n_last;
    logic    r_out_vld, n_out_vld;
    t_char   r_out_char, n_out_char;

    t_char   code;
    logic    emit;
    logic    out_free;
    logic    s1_adv;
    logic    in_acc;

    kma_scan u_scan (
        .i_key_matrix (r_km),
        .o_code       (code)
    );

    assign emit     = (code != r_last) && (code != NoCode);
    assign out_free = !r_out_vld || !i_stall;
    assign s1_adv   = r_s1_vld && (!emit || out_free);
    assign o_stall  = r_s1_vld && !s1_adv;
    assign in_acc   = i_valid && !o_stall;

    always_comb begin
        n_s1_vld   = r_s1_vld;
        n_last     = r_last;
        n_out_vld  = r_out_vld;
        n_out_char = r_out_char;
        if (in_acc) begin
            n_s1_vld = 1'b1;
        end else if (s1_adv) begin
            n_s1_vld = 1'b0;
        end
        if (s1_adv) begin
            n_last = code;
        end
        if (s1_adv && emit) begin
            n_out_vld  = 1'b1;
            n_out_char = code;
        end else if (!i_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_last    <= NoCode;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_last    <= n_last;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_km <= i_key_matrix;
        end
        r_out_char <= n_out_char;
    end

    assign o_valid     = r_out_vld;
    assign o_character = r_out_char;

    a_nonzero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_char != NoCode))
        else $error("zero character on output");

    a_emit_tracks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && emit) |=> (r_out_vld && (r_out_char == r_last)))
        else $error("emitted character differs from stored code");

    a_hold_on_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s1_adv) |=> (r_s1_vld && $stable(r_km) && $stable(r_last)))
        else $error("input register changed while blocked");

    a_no_emit_unchanged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && (code == r_last)) |=> $stable(r_last))
        else $error("stored code changed on repeated code");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// tb_top: self-checking bench for key_matrix_to_ascii; directed key table, then random
// keystroke sequences, with characters predicted per tick and checked in order.
// Depends on kma_pkg and the key_matrix_to_ascii RTL.
`timescale 1ns / 100ps

module tb_top;

    import kma_pkg::*;

    localparam int unsigned RandTicks = 950;
    localparam int unsigned IdleLimit = 2000;
    localparam int unsigned DrainCycles = 8;
    localparam int unsigned MaxReports = 10;

    localparam t_char AsciiAt    = 7'h40;
    localparam t_char AsciiBs    = 7'h08;
    localparam t_char AsciiSpace = 7'h20;
    localparam t_char AsciiLf    = 7'h0A;

    localparam int unsigned IdxLettersEnd = 27;
    localparam int unsigned IdxBackspace  = 29;
    localparam int unsigned IdxSpace      = 31;
    localparam int unsigned IdxZero       = 32;
    localparam int unsigned IdxComma      = 44;
    localparam int unsigned IdxEnter      = 48;

    localparam t_matrix AllKeys   = '1;
    localparam t_matrix ShiftMask = t_matrix'(1) << ShiftBit;

    typedef struct packed {
        t_matrix keys;
        logic    typed;
        logic    fires;
        t_char   ch;
    } t_key_row;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_valid = 1'b0;
    logic    i_stall = 1'b0;
    t_matrix i_key_matrix = '0;
    logic    o_stall;
    logic    o_valid;
    t_char   o_character;

    t_char       pending_chars[$];
    t_char       held_code = NoCode;
    int unsigned mismatches = 0;
    int unsigned chars_checked = 0;
    int unsigned ticks_sent = 0;
    int unsigned shifted_ticks = 0;
    int unsigned idle_cycles = 0;
    int unsigned burst_left = 0;
    int unsigned stall_window = 0;
    int unsigned stall_mode = 0;

    t_key_row key_rows [24] = '{
        '{t_matrix'(0),                                   1'b1, 1'b0, NoCode},
        '{AllKeys,                                        1'b1, 1'b1, 7'h40},
        '{AllKeys,                                        1'b1, 1'b0, NoCode},
        '{t_matrix'(0),                                   1'b1, 1'b0, NoCode},
        '{ShiftMask,                                      1'b1, 1'b0, NoCode},
        '{t_matrix'(1) << 48,                             1'b1, 1'b1, 7'h0A},
        '{(t_matrix'(1) << 48) | ShiftMask,               1'b1, 1'b0, NoCode},
        '{t_matrix'(1) << 32,                             1'b1, 1'b1, 7'h30},
        '{(t_matrix'(1) << 32) | ShiftMask,               1'b1, 1'b0, NoCode},
        '{t_matrix'(1) << 32,                             1'b1, 1'b1, 7'h30},
        '{t_matrix'(1) << 49,                             1'b1, 1'b0, NoCode},
        '{t_matrix'(1) << 27,                             1'b1, 1'b0, NoCode},
        '{t_matrix'(1) << 29,                             1'b1, 1'b1, 7'h08},
        '{t_matrix'(1) << 31,                             1'b1, 1'b1, 7'h20},
        '{t_matrix'(1) << 47,                             1'b1, 1'b1, 7'h2F},
        '{(t_matrix'(1) << 47) | ShiftMask,               1'b1, 1'b1, 7'h3F},
        '{(t_matrix'(1) << 33) | ShiftMask,               1'b1, 1'b1, 7'h21},
        '{(t_matrix'(1) << 1) | (t_matrix'(1) << 8),      1'b0, 1'b0, NoCode},
        '{t_matrix'(1) << 54,                             1'b0, 1'b0, NoCode},
        '{(t_matrix'(1) << 15) | (t_matrix'(1) << 54) | ShiftMask,
                                                          1'b0, 1'b0, NoCode},
        '{(t_matrix'(1) << 26) | (t_matrix'(1) << 40) | (t_matrix'(1) << 52),
                                                          1'b0, 1'b0, NoCode},
        '{(t_matrix'(1) << 44) | ShiftMask,               1'b0, 1'b0, NoCode},
        '{t_matrix'(1) << 28,                             1'b1, 1'b0, NoCode},
        '{t_matrix'(1),                                   1'b1, 1'b1, 7'h40}
    };

    key_matrix_to_ascii DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_key_matrix (i_key_matrix),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_character  (o_character)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_char key_code(input int unsigned idx, input logic shifted);
        if (idx >= TableLen) begin
            return NoCode;
        end
        if (idx < IdxLettersEnd) begin
            return t_char'(AsciiAt + idx);
        end
        if (idx == IdxBackspace) begin
            return AsciiBs;
        end
        if (idx == IdxSpace) begin
            return AsciiSpace;
        end
        if (idx == IdxEnter) begin
            return AsciiLf;
        end
        if (idx < IdxZero) begin
            return NoCode;
        end
        // digit row: plain codes index+16, shifted the index; swapped from comma on
        if (shifted) begin
            if (idx == IdxZero) begin
                return NoCode;
            end
            return (idx < IdxComma) ? t_char'(idx) : t_char'(idx + 16);
        end
        return (idx < IdxComma) ? t_char'(idx + 16) : t_char'(idx);
    endfunction

    function automatic t_char decode_matrix(input t_matrix keys);
        for (int unsigned col = 0; col < NumCols; col++) begin
            for (int unsigned row = 0; row < NumRows; row++) begin
                if (keys[row * NumCols + col]) begin
                    return key_code(col + NumCols * row, keys[ShiftBit]);
                end
            end
        end
        return NoCode;
    endfunction

    task automatic note_mismatch(input string what, input t_char want, input t_char got);
        if (mismatches < MaxReports) begin
            $display("%0t: %s: expected 0x%02h, got 0x%02h", $realtime, what, want, got);
        end
        mismatches++;
    endtask

    task automatic send_tick(input t_matrix keys, input logic typed, input logic fires,
                             input t_char typed_ch);
        t_char code;
        i_valid <= 1'b1;
        i_key_matrix <= keys;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        code = decode_matrix(keys);
        if (typed) begin
            if (fires) begin
                pending_chars.push_back(typed_ch);
            end
        end else if (code != held_code && code != NoCode) begin
            pending_chars.push_back(code);
        end
        held_code = code;
        ticks_sent++;
        if (keys[ShiftBit]) begin
            shifted_ticks++;
        end
        @(negedge i_clk);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 15);
        end else begin
            burst_left--;
        end
    endtask

    function automatic t_matrix single_key(input int unsigned idx);
        return t_matrix'(1) << idx;
    endfunction

    task automatic send_random_stroke();
        t_matrix keys;
        int unsigned kind;
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
            keys = single_key($urandom_range(0, ShiftBit - 1));
            if ($urandom_range(0, 2) == 0) begin
                keys |= ShiftMask;
            end
            if ($urandom_range(0, 4) == 0) begin
                keys |= single_key($urandom_range(0, ShiftBit - 1));
            end
            repeat ($urandom_range(1, 4)) send_tick(keys, 1'b0, 1'b0, NoCode);
            if ($urandom_range(0, 4) < 3) begin
                send_tick('0, 1'b0, 1'b0, NoCode);
            end
        end else if (kind == 6) begin
            send_tick(t_matrix'({$urandom, $urandom}), 1'b0, 1'b0, NoCode);
        end else if (kind == 7) begin
            keys = single_key($urandom_range(0, ShiftBit))
                 | single_key($urandom_range(0, ShiftBit))
                 | single_key($urandom_range(0, ShiftBit));
            send_tick(keys, 1'b0, 1'b0, NoCode);
        end else if (kind == 8) begin
            send_tick('0, 1'b0, 1'b0, NoCode);
        end else begin
            keys = ($urandom_range(0, 1) == 0) ? ShiftMask
                 : single_key($urandom_range(TableLen, ShiftBit));
            send_tick(keys, 1'b0, 1'b0, NoCode);
        end
    endtask

    // receiver stall: windows of no stall, light, heavy and periodic stalling
    always @(negedge i_clk) begin
        if (stall_window == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_window <= $urandom_range(10, 60);
        end else begin
            stall_window <= stall_window - 1;
        end
        case (stall_mode)
            0: begin
                i_stall <= 1'b0;
            end
            1: begin
                i_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
                i_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                i_stall <= (stall_window % 3 == 0);
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_chars.size() == 0) begin
                note_mismatch("character with none expected", NoCode, o_character);
            end else begin
                if (o_character !== pending_chars[0]) begin
                    note_mismatch("character", pending_chars[0], o_character);
                end
                void'(pending_chars.pop_front());
                chars_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IdleLimit) begin
            $display("timeout: no word moved for %0d cycles", IdleLimit);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned directed_ticks;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        burst_left = $urandom_range(1, 15);
        foreach (key_rows[i]) begin
            send_tick(key_rows[i].keys, key_rows[i].typed, key_rows[i].fires, key_rows[i].ch);
        end
        directed_ticks = ticks_sent;
        while (ticks_sent - directed_ticks < RandTicks) begin
            send_random_stroke();
        end
        i_valid <= 1'b0;
        while (pending_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);
        $display("ticks: %0d (%0d directed, %0d with shift held)",
                 ticks_sent, directed_ticks, shifted_ticks);
        $display("characters checked: %0d, mismatches: %0d, still expected: %0d",
                 chars_checked, mismatches, pending_chars.size());
        if (mismatches == 0 && pending_chars.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> key_matrix_to_ascii.f
rtl/kma_pkg.sv
rtl/kma_scan.sv
rtl/key_matrix_to_ascii.sv
tb/tb_top.sv
